// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PLQ_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Same, on the default clock and reset names.
`define PLQ_ASSERT_DEF(name, prop) `PLQ_ASSERT(name, clk_i, rst_ni, prop)

`endif

// ===== src/plq_pkg.sv =====
package plq_pkg;

  localparam int LW_W      = 12;  // line width, unsigned Q12.0
  localparam int COLOR_W   = 32;
  localparam int NORM_W    = 24;  // delta magnitudes are shifted below 2^24
  localparam int PROD_W    = 2 * NORM_W;
  localparam int ALU_W     = 50;  // holds the sum of two squares
  localparam int RAD_W     = 64;  // (dx^2 + dy^2) << 14
  localparam int RAD_SHIFT = 14;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 4;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int Q_W       = 12;  // perp magnitude, at most w/2 rounded
  localparam int PERP_W    = Q_W + 1;
  localparam int NUM_SHIFT = 8;   // numerator is my * w * 256 + 2 * len
  localparam int DIV_SHIFT = 2 + Q_W - 1;  // divisor 4 * len aligned to quotient msb
  localparam int CORNERS   = 6;
  localparam int CNT_W     = $clog2(SQRT_STEPS);

  typedef struct packed {
    logic [NORM_W-1:0] mul_a;
    logic [NORM_W-1:0] mul_b;
    logic [ALU_W-1:0]  op_a;
    logic [ALU_W-1:0]  op_b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [ALU_W-1:0]  res;
    logic              no_borrow;  // op_a >= op_b on a subtract
  } alu_rsp_t;

endpackage

// ===== src/plq_if.sv =====
interface plq_in_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  point_x;
  logic signed [COORD_WIDTH-1:0]  point_y;
  logic [plq_pkg::LW_W-1:0]       line_width;
  logic [plq_pkg::COLOR_W-1:0]    rgba_color;
  logic                           first_point;
  logic                           last_point;
  logic                           close_loop;

  modport source (
    output valid, point_x, point_y, line_width, rgba_color,
           first_point, last_point, close_loop,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, line_width, rgba_color,
           first_point, last_point, close_loop,
    output ready
  );
endinterface

interface plq_out_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  vertex_x;
  logic signed [COORD_WIDTH-1:0]  vertex_y;
  logic [plq_pkg::COLOR_W-1:0]    vertex_color;
  logic                           last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, vertex_color, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, vertex_color, last_vertex,
    output ready
  );
endinterface

// ===== src/plq_alu.sv =====
module plq_alu (
  input  plq_pkg::alu_req_t req_i,
  output plq_pkg::alu_rsp_t rsp_o
);
  import plq_pkg::*;

  logic [ALU_W-1:0] op_b_eff;
  logic [ALU_W:0]   sum;

  assign op_b_eff = req_i.sub ? ~req_i.op_b : req_i.op_b;
  assign sum = {1'b0, req_i.op_a} + {1'b0, op_b_eff} + (ALU_W + 1)'(req_i.sub);

  assign rsp_o.prod      = req_i.mul_a * req_i.mul_b;
  assign rsp_o.res       = sum[ALU_W-1:0];
  assign rsp_o.no_borrow = sum[ALU_W];
endmodule

// ===== src/plq_vtx.sv =====
module plq_vtx #(
  parameter int COORD_WIDTH = 16
) (
  input  logic signed [COORD_WIDTH-1:0]    pt_i,
  input  logic signed [plq_pkg::PERP_W-1:0] perp_i,
  input  logic                             minus_i,
  output logic signed [COORD_WIDTH-1:0]    vtx_o
);
  import plq_pkg::*;

  localparam int SUM_W = ((COORD_WIDTH > PERP_W) ? COORD_WIDTH : PERP_W) + 2;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [SUM_W-1:0] pt_e;
  logic signed [SUM_W-1:0] pp_e;
  logic signed [SUM_W-1:0] sum;

  assign pt_e = {{(SUM_W - COORD_WIDTH){pt_i[COORD_WIDTH-1]}}, pt_i};
  assign pp_e = {{(SUM_W - PERP_W){perp_i[PERP_W-1]}}, perp_i};
  assign sum  = minus_i ? (pt_e - pp_e) : (pt_e + pp_e);

  always_comb begin
    priority if (sum > SAT_HI) begin
      vtx_o = SAT_HI[COORD_WIDTH-1:0];
    end else if (sum < SAT_LO) begin
      vtx_o = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      vtx_o = sum[COORD_WIDTH-1:0];
    end
  end
endmodule

// ===== src/polyline_to_quad_expander_core.sv =====
// Thick polyline expander: one point in, six vertices out per nonzero segment.
// A segment runs setup and squares, then a 32-step square root and two 12-step
// divides on the shared add/subtract unit, then one vertex per cycle while the
// vertex sink is ready. A closed last point can add a second segment.
// Async active-low reset clears the sequencer, the point history and the count.
module polyline_to_quad_expander_core #(
  parameter int COORD_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plq_in_if.sink     pt_i,
  plq_out_if.source  vtx_o
);
  import plq_pkg::*;

  localparam int DELTA_W = COORD_WIDTH + 1;
  localparam int MAG_W   = (COORD_WIDTH > NORM_W) ? COORD_WIDTH : NORM_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_NORM  = 4'd2;
  localparam logic [3:0] S_SQX   = 4'd3;
  localparam logic [3:0] S_SQY   = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_NUM   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic signed [COORD_WIDTH-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic signed [COORD_WIDTH-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [1:0] pts_q, pts_d;
  logic b_pend_q, b_pend_d, last_seg_q, last_seg_d, sel_y_q, sel_y_d;
  logic ov_q, ov_d;

  logic [LW_W-1:0] w_q, w_d;
  logic [COLOR_W-1:0] col_q, col_d, ocol_q, ocol_d;
  logic signed [COORD_WIDTH-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic signed [COORD_WIDTH-1:0] ox_q, ox_d, oy_q, oy_d;
  logic olast_q, olast_d;
  logic dxneg_q, dxneg_d, dypos_q, dypos_d;
  logic [MAG_W-1:0] mx_q, mx_d, my_q, my_d;
  logic [PROD_W-1:0] acc_q, acc_d, p_q, p_d;
  logic [RAD_W-1:0] rad_q, rad_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ALU_W-1:0] num_q, num_d, dv_q, dv_d;
  logic [Q_W-1:0] quo_q, quo_d, px_q, px_d, py_q, py_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  plq_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Segment deltas and magnitudes
  logic [DELTA_W-1:0] dx, dy, mag_x, mag_y;
  assign dx = {bx_q[COORD_WIDTH-1], bx_q} - {ax_q[COORD_WIDTH-1], ax_q};
  assign dy = {by_q[COORD_WIDTH-1], by_q} - {ay_q[COORD_WIDTH-1], ay_q};
  assign mag_x = dx[DELTA_W-1] ? (~dx + 1'b1) : dx;
  assign mag_y = dy[DELTA_W-1] ? (~dy + 1'b1) : dy;

  // Square root step: bring down two radicand bits, trial subtract 4*root+1
  logic [REM_W-1:0] rem_sh, trial;
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  logic [Q_W-1:0] quo_nx;
  assign quo_nx = {quo_q[Q_W-2:0], alu_rsp.no_borrow};

  // Corner generation
  logic corner_end, corner_minus;
  logic signed [PERP_W-1:0] px_s, py_s, perp_x, perp_y;
  logic signed [COORD_WIDTH-1:0] cpt_x, cpt_y, vtx_x, vtx_y;

  always_comb begin
    unique case (cnt_q[2:0])
      3'd0:    begin corner_end = 1'b0; corner_minus = 1'b1; end  // top-left
      3'd1:    begin corner_end = 1'b0; corner_minus = 1'b0; end  // top-right
      3'd2:    begin corner_end = 1'b1; corner_minus = 1'b1; end  // bottom-left
      3'd3:    begin corner_end = 1'b0; corner_minus = 1'b0; end  // top-right
      3'd4:    begin corner_end = 1'b1; corner_minus = 1'b0; end  // bottom-right
      default: begin corner_end = 1'b1; corner_minus = 1'b1; end  // bottom-left
    endcase
  end

  assign px_s   = {1'b0, px_q};
  assign py_s   = {1'b0, py_q};
  assign perp_x = dypos_q ? -px_s : px_s;
  assign perp_y = dxneg_q ? -py_s : py_s;
  assign cpt_x  = corner_end ? bx_q : ax_q;
  assign cpt_y  = corner_end ? by_q : ay_q;

  plq_vtx #(.COORD_WIDTH(COORD_WIDTH)) u_vtx_x (
    .pt_i    (cpt_x),
    .perp_i  (perp_x),
    .minus_i (corner_minus),
    .vtx_o   (vtx_x)
  );

  plq_vtx #(.COORD_WIDTH(COORD_WIDTH)) u_vtx_y (
    .pt_i    (cpt_y),
    .perp_i  (perp_y),
    .minus_i (corner_minus),
    .vtx_o   (vtx_y)
  );

  // Accept-time decisions
  logic new_poly, do_a, do_b, accept, out_free;
  logic [1:0] pts_new;

  assign new_poly = pt_i.first_point || (pts_q == 2'd0);
  assign pts_new  = new_poly ? 2'd1 : ((pts_q == 2'd3) ? 2'd3 : pts_q + 2'd1);
  assign do_a     = !new_poly &&
                    ((pt_i.point_x != prev_x_q) || (pt_i.point_y != prev_y_q));
  assign do_b     = pt_i.last_point && pt_i.close_loop && (pts_new == 2'd3) &&
                    ((pt_i.point_x != start_x_q) || (pt_i.point_y != start_y_q));
  assign accept   = pt_i.valid && (state_q == S_IDLE);
  assign out_free = !ov_q || vtx_o.ready;

  assign pt_i.ready         = (state_q == S_IDLE);
  assign vtx_o.valid        = ov_q;
  assign vtx_o.vertex_x     = ox_q;
  assign vtx_o.vertex_y     = oy_q;
  assign vtx_o.vertex_color = ocol_q;
  assign vtx_o.last_vertex  = olast_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    start_x_d = start_x_q;
    start_y_d = start_y_q;
    pts_d     = pts_q;
    b_pend_d  = b_pend_q;
    last_seg_d = last_seg_q;
    sel_y_d   = sel_y_q;
    ov_d      = ov_q;
    w_d       = w_q;
    col_d     = col_q;
    ocol_d    = ocol_q;
    ax_d      = ax_q;
    ay_d      = ay_q;
    bx_d      = bx_q;
    by_d      = by_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    olast_d   = olast_q;
    dxneg_d   = dxneg_q;
    dypos_d   = dypos_q;
    mx_d      = mx_q;
    my_d      = my_q;
    acc_d     = acc_q;
    p_d       = p_q;
    rad_d     = rad_q;
    rem_d     = rem_q;
    root_d    = root_q;
    num_d     = num_q;
    dv_d      = dv_q;
    quo_d     = quo_q;
    px_d      = px_q;
    py_d      = py_q;
    alu_req   = '0;

    if (ov_q && vtx_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          prev_x_d = pt_i.point_x;
          prev_y_d = pt_i.point_y;
          w_d      = pt_i.line_width;
          col_d    = pt_i.rgba_color;
          if (new_poly) begin
            start_x_d = pt_i.point_x;
            start_y_d = pt_i.point_y;
          end
          pts_d      = pt_i.last_point ? 2'd0 : pts_new;
          b_pend_d   = do_a && do_b;
          last_seg_d = !(do_a && do_b);
          if (do_a) begin
            ax_d    = prev_x_q;
            ay_d    = prev_y_q;
            bx_d    = pt_i.point_x;
            by_d    = pt_i.point_y;
            state_d = S_SETUP;
          end else if (do_b) begin
            ax_d    = pt_i.point_x;
            ay_d    = pt_i.point_y;
            bx_d    = start_x_q;
            by_d    = start_y_q;
            state_d = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        mx_d    = MAG_W'(mag_x[COORD_WIDTH-1:0]);
        my_d    = MAG_W'(mag_y[COORD_WIDTH-1:0]);
        dxneg_d = dx[DELTA_W-1];
        dypos_d = !dy[DELTA_W-1] && (dy != '0);
        state_d = S_NORM;
      end
      S_NORM: begin
        // very large deltas lose one bit a cycle until both fit
        if (((mx_q >> NORM_W) != '0) || ((my_q >> NORM_W) != '0)) begin
          mx_d = mx_q >> 1;
          my_d = my_q >> 1;
        end else begin
          state_d = S_SQX;
        end
      end
      S_SQX: begin
        alu_req.mul_a = mx_q[NORM_W-1:0];
        alu_req.mul_b = mx_q[NORM_W-1:0];
        acc_d   = alu_rsp.prod;
        state_d = S_SQY;
      end
      S_SQY: begin
        alu_req.mul_a = my_q[NORM_W-1:0];
        alu_req.mul_b = my_q[NORM_W-1:0];
        p_d     = alu_rsp.prod;
        state_d = S_SUM;
      end
      S_SUM: begin
        alu_req.op_a = ALU_W'(acc_q);
        alu_req.op_b = ALU_W'(p_q);
        rad_d   = {alu_rsp.res, {RAD_SHIFT{1'b0}}};
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        alu_req.op_a = ALU_W'(rem_sh);
        alu_req.op_b = ALU_W'(trial);
        alu_req.sub  = 1'b1;
        if (alu_rsp.no_borrow) begin
          rem_d  = alu_rsp.res[REM_W-1:0];
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        rad_d = rad_q << 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          sel_y_d = 1'b0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // perp x scales |dy|, perp y scales |dx|
        alu_req.mul_a = sel_y_q ? mx_q[NORM_W-1:0] : my_q[NORM_W-1:0];
        alu_req.mul_b = NORM_W'(w_q);
        p_d     = alu_rsp.prod;
        state_d = S_NUM;
      end
      S_NUM: begin
        alu_req.op_a = ALU_W'({p_q, {NUM_SHIFT{1'b0}}});
        alu_req.op_b = ALU_W'({root_q, 1'b0});
        num_d   = alu_rsp.res;
        dv_d    = ALU_W'({root_q, {DIV_SHIFT{1'b0}}});
        quo_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        alu_req.op_a = num_q;
        alu_req.op_b = dv_q;
        alu_req.sub  = 1'b1;
        if (alu_rsp.no_borrow) begin
          num_d = alu_rsp.res;
        end
        quo_d = quo_nx;
        dv_d  = dv_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(Q_W - 1)) begin
          cnt_d = '0;
          if (sel_y_q) begin
            py_d    = quo_nx;
            state_d = S_EMIT;
          end else begin
            px_d    = quo_nx;
            sel_y_d = 1'b1;
            state_d = S_MUL;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ox_d    = vtx_x;
          oy_d    = vtx_y;
          ocol_d  = col_q;
          olast_d = last_seg_q && (cnt_q == CNT_W'(CORNERS - 1));
          cnt_d   = cnt_q + 1'b1;
          if (cnt_q == CNT_W'(CORNERS - 1)) begin
            cnt_d = '0;
            if (b_pend_q) begin
              // closing segment: from this point back to the polyline start
              ax_d       = prev_x_q;
              ay_d       = prev_y_q;
              bx_d       = start_x_q;
              by_d       = start_y_q;
              b_pend_d   = 1'b0;
              last_seg_d = 1'b1;
              state_d    = S_SETUP;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      start_x_q  <= '0;
      start_y_q  <= '0;
      pts_q      <= '0;
      b_pend_q   <= 1'b0;
      last_seg_q <= 1'b0;
      sel_y_q    <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      prev_x_q   <= prev_x_d;
      prev_y_q   <= prev_y_d;
      start_x_q  <= start_x_d;
      start_y_q  <= start_y_d;
      pts_q      <= pts_d;
      b_pend_q   <= b_pend_d;
      last_seg_q <= last_seg_d;
      sel_y_q    <= sel_y_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    col_q   <= col_d;
    ocol_q  <= ocol_d;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    olast_q <= olast_d;
    dxneg_q <= dxneg_d;
    dypos_q <= dypos_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
    acc_q   <= acc_d;
    p_q     <= p_d;
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    num_q   <= num_d;
    dv_q    <= dv_d;
    quo_q   <= quo_d;
    px_q    <= px_d;
    py_q    <= py_d;
  end
endmodule

// ===== src/plq_chk.sv =====
`include "assert_macros.svh"

module plq_chk #(
  parameter int COORD_WIDTH = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          pt_ready_i,
  input logic                          vtx_valid_i,
  input logic                          vtx_ready_i,
  input logic [COORD_WIDTH-1:0]        vtx_x_i,
  input logic [COORD_WIDTH-1:0]        vtx_y_i,
  input logic [plq_pkg::COLOR_W-1:0]   vtx_color_i,
  input logic                          vtx_last_i
);
  import plq_pkg::*;

  // position of the next output beat within its group of corners
  logic [2:0] beat_cnt_q, beat_cnt_d;
  logic       vtx_beat;

  assign vtx_beat = vtx_valid_i && vtx_ready_i;

  always_comb begin
    beat_cnt_d = beat_cnt_q;
    if (vtx_beat) begin
      if (vtx_last_i || (beat_cnt_q == 3'(CORNERS - 1))) begin
        beat_cnt_d = '0;
      end else begin
        beat_cnt_d = beat_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_cnt_q <= '0;
    end else begin
      beat_cnt_q <= beat_cnt_d;
    end
  end

  // last_vertex only ever closes a complete quad
  `PLQ_ASSERT_DEF(a_last_on_sixth, vtx_beat && vtx_last_i |-> beat_cnt_q == 3'(CORNERS - 1))

  // vertices are produced only while the input side is busy
  `PLQ_ASSERT_DEF(a_emit_while_busy, $rose(vtx_valid_i) |-> $past(!pt_ready_i))

  `PLQ_ASSERT_DEF(a_vtx_hold, vtx_valid_i && !vtx_ready_i |=> vtx_valid_i && $stable(vtx_x_i) && $stable(vtx_y_i) && $stable(vtx_color_i) && $stable(vtx_last_i))

  `PLQ_ASSERT_DEF(a_vtx_drop, $fell(vtx_valid_i) |-> $past(vtx_ready_i))

endmodule

bind polyline_to_quad_expander_core plq_chk #(
  .COORD_WIDTH (COORD_WIDTH)
) u_plq_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pt_ready_i  (pt_i.ready),
  .vtx_valid_i (vtx_o.valid),
  .vtx_ready_i (vtx_o.ready),
  .vtx_x_i     (vtx_o.vertex_x),
  .vtx_y_i     (vtx_o.vertex_y),
  .vtx_color_i (vtx_o.vertex_color),
  .vtx_last_i  (vtx_o.last_vertex)
);

// ===== verif/polyline_to_quad_expander_core_tb.sv =====
module polyline_to_quad_expander_core_tb;

  localparam int CW = 16;

  typedef struct {
    logic signed [CW-1:0]           x;
    logic signed [CW-1:0]           y;
    logic [plq_pkg::LW_W-1:0]       w;
    logic [plq_pkg::COLOR_W-1:0]    rgba;
    logic                           first_pt;
    logic                           last_pt;
    logic                           close;
  } pt_item_t;

  typedef struct packed {
    logic signed [CW-1:0]           x;
    logic signed [CW-1:0]           y;
    logic [plq_pkg::COLOR_W-1:0]    color;
    logic                           last;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  plq_in_if  #(.COORD_WIDTH(CW)) pt_if  ();
  plq_out_if #(.COORD_WIDTH(CW)) vtx_if ();

  polyline_to_quad_expander_core #(.COORD_WIDTH(CW)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_if),
    .vtx_o  (vtx_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pt_item_t stroke_q[$];
  vertex_t  owed_vertices[$];
  vertex_t  seg_buf[$];

  // expander state as the block should hold it
  longint   prev_x, prev_y, start_x, start_y;
  int       pts_in_line;

  int total_points, points_sent, vertices_checked, mismatches;
  int quads_built, closing_quads;
  int in_gap, in_quiet, out_stall, out_quiet;
  pt_item_t drv_item, got_item;
  vertex_t  want;

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r, t;
    r = 0;
    for (int b = 27; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  task automatic push_corner(longint x, longint y, logic [plq_pkg::COLOR_W-1:0] col);
    vertex_t v;
    v.x = clamp_coord(x);
    v.y = clamp_coord(y);
    v.color = col;
    v.last = 1'b0;
    seg_buf.insert(seg_buf.size(), v);
  endtask

  // two triangles around segment a->b, offset sideways by half the width
  task automatic widen_segment(longint ax, longint ay, longint bx, longint by,
                               longint w, logic [plq_pkg::COLOR_W-1:0] col);
    longint dx, dy, mx, my, len, px, py, sx, sy;
    dx = bx - ax;
    dy = by - ay;
    if (dx == 0 && dy == 0) return;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    // length in 1/128 of a coordinate step
    len = floor_sqrt((mx * mx + my * my) << 14);
    // round half away from zero on the magnitude, then apply the sign
    px = (my * w * 128 + len) / (2 * len);
    py = (mx * w * 128 + len) / (2 * len);
    sx = dy > 0 ? -px : px;
    sy = dx < 0 ? -py : py;
    push_corner(ax - sx, ay - sy, col);
    push_corner(ax + sx, ay + sy, col);
    push_corner(bx - sx, by - sy, col);
    push_corner(ax + sx, ay + sy, col);
    push_corner(bx + sx, by + sy, col);
    push_corner(bx - sx, by - sy, col);
    quads_built++;
  endtask

  task automatic expand_point(pt_item_t p);
    vertex_t v;
    longint  x, y;
    x = p.x;
    y = p.y;
    seg_buf = {};
    if (p.first_pt || pts_in_line == 0) begin
      start_x = x;
      start_y = y;
      pts_in_line = 1;
    end else begin
      widen_segment(prev_x, prev_y, x, y, p.w, p.rgba);
      if (pts_in_line < 3) pts_in_line++;
    end
    prev_x = x;
    prev_y = y;
    if (p.last_pt) begin
      if (p.close && pts_in_line == 3) begin
        widen_segment(x, y, start_x, start_y, p.w, p.rgba);
        closing_quads++;
      end
      pts_in_line = 0;
    end
    if (seg_buf.size() > 0) begin
      v = seg_buf[seg_buf.size() - 1];
      v.last = 1'b1;
      seg_buf[seg_buf.size() - 1] = v;
    end
    foreach (seg_buf[i]) owed_vertices.insert(owed_vertices.size(), seg_buf[i]);
  endtask

  task automatic check_field(string what, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    end
  endtask

  task automatic add_pt(int x, int y, int w, logic [31:0] col,
                        bit f, bit l, bit c);
    pt_item_t p;
    p.x = x[CW-1:0];
    p.y = y[CW-1:0];
    p.w = w[plq_pkg::LW_W-1:0];
    p.rgba = col;
    p.first_pt = f;
    p.last_pt = l;
    p.close = c;
    stroke_q.insert(stroke_q.size(), p);
  endtask

  // point driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        got_item.x = pt_if.point_x;
        got_item.y = pt_if.point_y;
        got_item.w = pt_if.line_width;
        got_item.rgba = pt_if.rgba_color;
        got_item.first_pt = pt_if.first_point;
        got_item.last_pt = pt_if.last_point;
        got_item.close = pt_if.close_loop;
        expand_point(got_item);
        points_sent++;
      end
      if (!pt_if.valid || pt_if.ready) begin
        if (in_gap > 0) begin
          pt_if.valid <= 1'b0;
          in_gap--;
        end else if (stroke_q.size() > 0) begin
          drv_item = stroke_q.pop_front();
          pt_if.point_x <= drv_item.x;
          pt_if.point_y <= drv_item.y;
          pt_if.line_width <= drv_item.w;
          pt_if.rgba_color <= drv_item.rgba;
          pt_if.first_point <= drv_item.first_pt;
          pt_if.last_point <= drv_item.last_pt;
          pt_if.close_loop <= drv_item.close;
          pt_if.valid <= 1'b1;
          in_gap = pick_gap(in_quiet);
        end else begin
          pt_if.valid <= 1'b0;
        end
      end
    end
  end

  // vertex monitor and sink stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (vtx_if.valid && vtx_if.ready) begin
        if (owed_vertices.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected vertex, expected none, actual x=%0d y=%0d color=%0h last=%0b",
                   $time, vtx_if.vertex_x, vtx_if.vertex_y, vtx_if.vertex_color,
                   vtx_if.last_vertex);
        end else begin
          want = owed_vertices.pop_front();
          check_field("vertex_x", want.x, vtx_if.vertex_x);
          check_field("vertex_y", want.y, vtx_if.vertex_y);
          check_field("vertex_color", want.color, vtx_if.vertex_color);
          check_field("last_vertex", want.last, vtx_if.last_vertex);
        end
        vertices_checked++;
        out_stall = pick_gap(out_quiet);
      end else if ($urandom_range(0, 19) == 0) begin
        out_stall = pick_gap(out_quiet);
      end
      if (out_stall > 0) begin
        vtx_if.ready <= 1'b0;
        out_stall--;
      end else begin
        vtx_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int rand_items, n, kind, r, x, y, w;
    logic [31:0] col;
    bit c;

    rst_ni = 1'b0;
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.line_width = '0;
    pt_if.rgba_color = '0;
    pt_if.first_point = 1'b0;
    pt_if.last_point = 1'b0;
    pt_if.close_loop = 1'b0;
    vtx_if.ready = 1'b0;
    pts_in_line = 0;
    prev_x = 0;
    prev_y = 0;
    start_x = 0;
    start_y = 0;

    // square loop; the opening point carries no first mark
    add_pt(0, 0, 16, 32'h1122_3344, 0, 0, 0);
    add_pt(160, 0, 16, 32'h1122_3344, 0, 0, 0);
    add_pt(160, 160, 16, 32'h5566_7788, 0, 0, 0);
    add_pt(0, 160, 32, 32'h99aa_bbcc, 0, 1, 1);
    // repeated points make no quad
    add_pt(100, 100, 24, 32'h0, 1, 0, 0);
    add_pt(100, 100, 24, 32'h0, 0, 0, 0);
    add_pt(100, 100, 24, 32'h0, 0, 1, 0);
    // lone point, and a two-point loop that cannot close
    add_pt(5, 5, 40, 32'hffff_ffff, 1, 1, 1);
    add_pt(0, 0, 40, 32'h0f0f_0f0f, 1, 0, 0);
    add_pt(320, 48, 40, 32'hf0f0_f0f0, 0, 1, 1);
    // corners of the coordinate range, widest and zero width, saturation
    add_pt(-32768, -32768, 4095, 32'h0, 0, 0, 0);
    add_pt(32767, 32767, 4095, 32'hffff_ffff, 0, 0, 1);
    add_pt(32767, -32768, 0, 32'h8000_0001, 0, 0, 0);
    add_pt(-32768, 32767, 4095, 32'h7fff_fffe, 0, 1, 1);
    add_pt(1, 0, 4095, 32'hdead_beef, 1, 0, 0);
    add_pt(0, 1, 4095, 32'hdead_beef, 0, 1, 0);
    // restart in the middle of a line
    add_pt(10, 10, 8, 32'h1234_5678, 1, 0, 0);
    add_pt(20, 30, 8, 32'h1234_5678, 0, 0, 0);
    add_pt(-50, 7, 8, 32'h1234_5678, 1, 0, 0);
    add_pt(-50, -200, 8, 32'h1234_5678, 0, 0, 0);
    add_pt(-300, -201, 1, 32'h0000_00ff, 0, 1, 1);

    rand_items = 0;
    while (rand_items < 370) begin
      if ($urandom_range(0, 99) < 85) begin
        n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
        kind = $urandom_range(0, 2);
        x = int'($urandom_range(0, 65535)) - 32768;
        y = int'($urandom_range(0, 65535)) - 32768;
        r = $urandom_range(0, 9);
        w = (r == 0) ? 0 : (r == 1) ? 4095 : (r < 5) ? $urandom_range(1, 64)
                                                      : $urandom_range(0, 4095);
        col = $urandom;
        c = 1'($urandom_range(0, 1));
        for (int k = 0; k < n; k++) begin
          if (k == 0 || $urandom_range(0, 11) != 0) begin
            case (kind)
              0: begin
                x = x + int'($urandom_range(0, 600)) - 300;
                y = y + int'($urandom_range(0, 600)) - 300;
              end
              1: begin
                x = int'($urandom_range(0, 65535)) - 32768;
                y = int'($urandom_range(0, 65535)) - 32768;
              end
              default: begin
                x = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 64))
                                         : -32768 + int'($urandom_range(0, 64));
                y = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 64))
                                         : -32768 + int'($urandom_range(0, 64));
              end
            endcase
          end
          if ($urandom_range(0, 3) == 0) col = $urandom;
          add_pt(x, y, w, col, k == 0, k == n - 1, c);
          rand_items++;
        end
      end else begin
        add_pt(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
               int'($urandom_range(0, 4095)), $urandom, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        rand_items++;
      end
    end
    total_points = stroke_q.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (points_sent < total_points) @(posedge clk_i);
    while (owed_vertices.size() != 0) @(posedge clk_i);
    // catch any stray vertex after the last owed one
    repeat (150) @(posedge clk_i);

    $display("%0d points in, %0d vertices checked, %0d quads of which %0d closing",
             points_sent, vertices_checked, quads_built, closing_quads);
    if (mismatches == 0) begin
      $display("polyline_to_quad_expander_core_tb: clean");
    end else begin
      $display("polyline_to_quad_expander_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d of %0d points sent, %0d vertices owed",
             $time, points_sent, total_points, owed_vertices.size());
    $display("polyline_to_quad_expander_core_tb: errors");
    $finish;
  end

endmodule
